// ===== design/ucer_pkg.sv =====
`default_nettype none

package ucer_pkg;

    // Configuration register indexes (byte address is four times the index).
    localparam int unsigned APB_ADDR_W = 5;
    localparam int unsigned APB_DATA_W = 32;
    localparam logic [2:0] REG_MAX_PACKET  = 3'd0;
    localparam logic [2:0] REG_DEVICE_LEN  = 3'd1;
    localparam logic [2:0] REG_CONFIG_LEN  = 3'd2;
    localparam logic [2:0] REG_REPORT_LEN  = 3'd3;
    localparam logic [2:0] REG_LANG_LEN    = 3'd4;
    localparam logic [2:0] REG_VENDOR_LEN  = 3'd5;
    localparam logic [2:0] REG_PRODUCT_LEN = 3'd6;
    localparam logic [2:0] REG_SERIAL_LEN  = 3'd7;

    // Register reset values.
    localparam logic [1:0] RST_MAX_PACKET  = 2'd1;
    localparam logic [7:0] RST_DEVICE_LEN  = 8'd18;
    localparam logic [7:0] RST_CONFIG_LEN  = 8'd34;
    localparam logic [7:0] RST_REPORT_LEN  = 8'd52;
    localparam logic [7:0] RST_LANG_LEN    = 8'd4;
    localparam logic [7:0] RST_VENDOR_LEN  = 8'd94;
    localparam logic [7:0] RST_PRODUCT_LEN = 8'd26;
    localparam logic [7:0] RST_SERIAL_LEN  = 8'd22;

    // Event codes on the request channel.
    localparam logic [1:0] FUNC_SETUP     = 2'd0;
    localparam logic [1:0] FUNC_IN_DONE   = 2'd1;
    localparam logic [1:0] FUNC_BUS_RESET = 2'd2;

    // Response actions.
    localparam logic [1:0] ACT_IN_PACKET   = 2'd0;
    localparam logic [1:0] ACT_SET_ADDRESS = 2'd1;
    localparam logic [1:0] ACT_SET_CONFIG  = 2'd2;

    // Descriptor sources.
    localparam logic [2:0] SRC_DEVICE  = 3'd0;
    localparam logic [2:0] SRC_CONFIG  = 3'd1;
    localparam logic [2:0] SRC_LANG    = 3'd2;
    localparam logic [2:0] SRC_VENDOR  = 3'd3;
    localparam logic [2:0] SRC_PRODUCT = 3'd4;
    localparam logic [2:0] SRC_SERIAL  = 3'd5;
    localparam logic [2:0] SRC_REPORT  = 3'd6;
    localparam logic [2:0] SRC_NONE    = 3'd7;

    // Setup packet decoding.
    localparam int unsigned DIR_IN_BIT = 7;
    localparam logic [1:0] KIND_STANDARD = 2'd0;
    localparam logic [1:0] KIND_CLASS    = 2'd1;
    localparam logic [7:0] REQ_SET_ADDRESS = 8'h05;
    localparam logic [7:0] REQ_READ_DESC   = 8'h06;
    localparam logic [7:0] REQ_SET_CONFIG  = 8'h09;
    localparam logic [7:0] REQ_SET_IDLE    = 8'h0A;
    localparam logic [7:0] DT_DEVICE = 8'h01;
    localparam logic [7:0] DT_CONFIG = 8'h02;
    localparam logic [7:0] DT_STRING = 8'h03;
    localparam logic [7:0] DT_REPORT = 8'h22;
    localparam logic [7:0] STR_LANG    = 8'd0;
    localparam logic [7:0] STR_VENDOR  = 8'd1;
    localparam logic [7:0] STR_PRODUCT = 8'd2;
    localparam logic [7:0] STR_SERIAL  = 8'd3;

    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  request_type;
        logic [7:0]  request_code;
        logic [15:0] request_value;
        logic [15:0] request_length;
    } req_t;

    typedef struct packed {
        logic [1:0] action;
        logic [2:0] source;
        logic [7:0] offset;
        logic [6:0] count;
        logic [7:0] argument;
        logic       last;
    } rsp_t;

    typedef struct packed {
        logic [1:0] max_packet_code;
        logic [7:0] device_len;
        logic [7:0] config_len;
        logic [7:0] report_len;
        logic [7:0] lang_len;
        logic [7:0] vendor_str_len;
        logic [7:0] product_str_len;
        logic [7:0] serial_str_len;
    } cfg_t;

    // One queued job: a single response, or a command followed by a status packet.
    typedef struct packed {
        logic       two;
        logic [1:0] action;
        logic [2:0] source;
        logic [7:0] offset;
        logic [6:0] count;
        logic [7:0] argument;
    } job_t;

endpackage

`default_nettype wire

// ===== design/ucer_if.sv =====
`default_nettype none

interface ucer_req_if import ucer_pkg::*;;
    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ucer_rsp_if import ucer_pkg::*;;
    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/ucer_regs.sv =====
`default_nettype none

module ucer_regs import ucer_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[4:2];
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_MAX_PACKET:  cfg_next.max_packet_code = pwdata[1:0];
                REG_DEVICE_LEN:  cfg_next.device_len      = pwdata[7:0];
                REG_CONFIG_LEN:  cfg_next.config_len      = pwdata[7:0];
                REG_REPORT_LEN:  cfg_next.report_len      = pwdata[7:0];
                REG_LANG_LEN:    cfg_next.lang_len        = pwdata[7:0];
                REG_VENDOR_LEN:  cfg_next.vendor_str_len  = pwdata[7:0];
                REG_PRODUCT_LEN: cfg_next.product_str_len = pwdata[7:0];
                REG_SERIAL_LEN:  cfg_next.serial_str_len  = pwdata[7:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_MAX_PACKET:  prdata = {{(APB_DATA_W-2){1'b0}}, cfg_reg.max_packet_code};
            REG_DEVICE_LEN:  prdata = {{(APB_DATA_W-8){1'b0}}, cfg_reg.device_len};
            REG_CONFIG_LEN:  prdata = {{(APB_DATA_W-8){1'b0}}, cfg_reg.config_len};
            REG_REPORT_LEN:  prdata = {{(APB_DATA_W-8){1'b0}}, cfg_reg.report_len};
            REG_LANG_LEN:    prdata = {{(APB_DATA_W-8){1'b0}}, cfg_reg.lang_len};
            REG_VENDOR_LEN:  prdata = {{(APB_DATA_W-8){1'b0}}, cfg_reg.vendor_str_len};
            REG_PRODUCT_LEN: prdata = {{(APB_DATA_W-8){1'b0}}, cfg_reg.product_str_len};
            REG_SERIAL_LEN:  prdata = {{(APB_DATA_W-8){1'b0}}, cfg_reg.serial_str_len};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_packet_code <= RST_MAX_PACKET;
            cfg_reg.device_len      <= RST_DEVICE_LEN;
            cfg_reg.config_len      <= RST_CONFIG_LEN;
            cfg_reg.report_len      <= RST_REPORT_LEN;
            cfg_reg.lang_len        <= RST_LANG_LEN;
            cfg_reg.vendor_str_len  <= RST_VENDOR_LEN;
            cfg_reg.product_str_len <= RST_PRODUCT_LEN;
            cfg_reg.serial_str_len  <= RST_SERIAL_LEN;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/ucer_front.sv =====
`default_nettype none

module ucer_front import ucer_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    ucer_req_if.sink  req,
    input  cfg_t      cfg,
    input  wire logic queue_full,
    output logic      push,
    output job_t      push_job
);

    logic [7:0] rem_reg;
    logic [7:0] rem_next;
    logic [7:0] off_reg;
    logic [7:0] off_next;
    logic [2:0] src_reg;
    logic [2:0] src_next;
    logic       zlp_reg;
    logic       zlp_next;

    logic       fire;
    logic [6:0] mp;
    logic [7:0] mp_w;
    logic [7:0] dtype;
    logic [7:0] idx;
    logic       desc_hit;
    logic [2:0] desc_src;
    logic [7:0] desc_len;
    logic       dir_in;
    logic [1:0] kind;
    logic       use_send;
    logic [7:0] chunk;
    logic       job_valid;

    assign req.ready = !queue_full;
    assign fire      = req.valid && req.ready;
    assign push      = fire && job_valid;

    assign mp     = 7'd8 << cfg.max_packet_code;
    assign mp_w   = {1'b0, mp};
    assign dtype  = req.data.request_value[15:8];
    assign idx    = req.data.request_value[7:0];
    assign dir_in = req.data.request_type[DIR_IN_BIT];
    assign kind   = req.data.request_type[6:5];

    // Descriptor selected by wValue; a string index past the table is empty.
    always_comb
    begin
        desc_hit = 1'b1;
        desc_src = SRC_NONE;
        desc_len = 8'd0;
        case (dtype)
            DT_DEVICE:
            begin
                desc_src = SRC_DEVICE;
                desc_len = cfg.device_len;
            end
            DT_CONFIG:
            begin
                desc_src = SRC_CONFIG;
                desc_len = cfg.config_len;
            end
            DT_REPORT:
            begin
                desc_src = SRC_REPORT;
                desc_len = cfg.report_len;
            end
            DT_STRING:
            begin
                case (idx)
                    STR_LANG:
                    begin
                        desc_src = SRC_LANG;
                        desc_len = cfg.lang_len;
                    end
                    STR_VENDOR:
                    begin
                        desc_src = SRC_VENDOR;
                        desc_len = cfg.vendor_str_len;
                    end
                    STR_PRODUCT:
                    begin
                        desc_src = SRC_PRODUCT;
                        desc_len = cfg.product_str_len;
                    end
                    STR_SERIAL:
                    begin
                        desc_src = SRC_SERIAL;
                        desc_len = cfg.serial_str_len;
                    end
                    default:
                    begin
                        desc_src = SRC_NONE;
                        desc_len = 8'd0;
                    end
                endcase
            end
            default:
            begin
                desc_hit = 1'b0;
            end
        endcase
    end

    // Decode the request, update the transfer state and build at most one job.
    // A descriptor read first loads the transfer, then sends its first packet
    // exactly as an IN-complete event would.
    always_comb
    begin
        rem_next  = rem_reg;
        off_next  = off_reg;
        src_next  = src_reg;
        zlp_next  = zlp_reg;
        use_send  = 1'b0;
        job_valid = 1'b0;
        chunk     = 8'd0;
        push_job  = '0;
        push_job.action = ACT_IN_PACKET;
        push_job.source = SRC_NONE;
        if (fire)
        begin
            case (req.data.func)
                FUNC_IN_DONE:
                begin
                    use_send = 1'b1;
                end
                FUNC_BUS_RESET:
                begin
                    rem_next = 8'd0;
                    off_next = 8'd0;
                    src_next = SRC_NONE;
                    zlp_next = 1'b0;
                end
                FUNC_SETUP:
                begin
                    // Every setup drops the transfer in progress.
                    rem_next = 8'd0;
                    off_next = 8'd0;
                    src_next = SRC_NONE;
                    zlp_next = 1'b0;
                    if (dir_in)
                    begin
                        if (kind == KIND_STANDARD && req.data.request_code == REQ_READ_DESC &&
                            desc_hit)
                        begin
                            src_next = desc_src;
                            if (req.data.request_length > {8'd0, desc_len})
                            begin
                                // Short reply: owes a zero-length packet when it
                                // fills its last packet exactly.
                                rem_next = desc_len;
                                zlp_next = ((desc_len & (mp_w - 8'd1)) == 8'd0);
                            end
                            else
                            begin
                                rem_next = req.data.request_length[7:0];
                                zlp_next = 1'b0;
                            end
                            use_send = 1'b1;
                        end
                    end
                    else if (kind == KIND_STANDARD &&
                             req.data.request_code == REQ_SET_ADDRESS)
                    begin
                        job_valid         = 1'b1;
                        push_job.two      = 1'b1;
                        push_job.action   = ACT_SET_ADDRESS;
                        push_job.argument = req.data.request_value[7:0];
                    end
                    else if (kind == KIND_STANDARD &&
                             req.data.request_code == REQ_SET_CONFIG)
                    begin
                        job_valid         = 1'b1;
                        push_job.two      = 1'b1;
                        push_job.action   = ACT_SET_CONFIG;
                        push_job.argument = req.data.request_value[7:0];
                    end
                    else if (kind == KIND_CLASS && req.data.request_code == REQ_SET_IDLE)
                    begin
                        job_valid = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase

            if (use_send)
            begin
                if (rem_next != 8'd0)
                begin
                    chunk           = (rem_next > mp_w) ? mp_w : rem_next;
                    job_valid       = 1'b1;
                    push_job.source = src_next;
                    push_job.offset = off_next;
                    push_job.count  = chunk[6:0];
                    off_next        = off_next + chunk;
                    rem_next        = rem_next - chunk;
                end
                else if (zlp_next)
                begin
                    job_valid       = 1'b1;
                    push_job.source = src_next;
                    push_job.offset = off_next;
                    zlp_next        = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= 8'd0;
            off_reg <= 8'd0;
            src_reg <= SRC_NONE;
            zlp_reg <= 1'b0;
        end
        else
        begin
            rem_reg <= rem_next;
            off_reg <= off_next;
            src_reg <= src_next;
            zlp_reg <= zlp_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/ucer_fifo.sv =====
`default_nettype none

module ucer_fifo import ucer_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  job_t      push_job,
    input  wire logic pop,
    output job_t      head,
    output logic      empty,
    output logic      full
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic             do_push;
    logic             do_pop;

    assign empty   = (fill_reg == '0);
    assign full    = (fill_reg == CNT_W'(DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/ucer_back.sv =====
`default_nettype none

module ucer_back import ucer_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  job_t      head,
    input  wire logic empty,
    output logic      pop,
    ucer_rsp_if.source rsp
);

    logic out_valid_reg;
    logic out_valid_next;
    rsp_t out_reg;
    rsp_t out_next;
    logic status_due_reg;
    logic status_due_next;
    logic load;

    assign load      = !out_valid_reg || rsp.ready;
    assign pop       = load && !status_due_reg && !empty;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        status_due_next = status_due_reg;
        if (load)
        begin
            if (status_due_reg)
            begin
                // Status stage that follows a command.
                out_valid_next    = 1'b1;
                out_next.action   = ACT_IN_PACKET;
                out_next.source   = SRC_NONE;
                out_next.offset   = '0;
                out_next.count    = '0;
                out_next.argument = '0;
                out_next.last     = 1'b1;
                status_due_next   = 1'b0;
            end
            else if (!empty)
            begin
                out_valid_next    = 1'b1;
                out_next.action   = head.action;
                out_next.source   = head.source;
                out_next.offset   = head.offset;
                out_next.count    = head.count;
                out_next.argument = head.argument;
                out_next.last     = !head.two;
                status_due_next   = head.two;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            status_due_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            status_due_reg <= status_due_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/usb_control_endpoint_responder_unit.sv =====
`default_nettype none

// A response passes through the job queue and the back end's registered output, and
// the status packet of a command follows once the command has been taken.
// Throughput: one request per cycle while the queue is not full; a request that gives
// a command and a status packet yields two responses; the queue absorbs bursts.
// Reset (rst_n, asynchronous, active low) empties the queue and output, clears the
// transfer state, and loads the configuration registers with their defaults.

module usb_control_endpoint_responder_unit import ucer_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    ucer_req_if.sink                   req,
    ucer_rsp_if.source                 rsp,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    cfg_t cfg;
    logic push;
    job_t push_job;
    logic pop;
    job_t head;
    logic empty;
    logic full;

    // Configuration registers: descriptor lengths and endpoint zero packet size.
    ucer_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The front end decodes each request, keeps the transfer state (source,
    // offset, bytes left, zero-length packet owed) and queues the resulting job.
    ucer_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .cfg        (cfg),
        .queue_full (full),
        .push       (push),
        .push_job   (push_job)
    );

    // The queue lets the front end keep taking requests while the output stalls.
    ucer_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .empty    (empty),
        .full     (full)
    );

    // The back end drives the registered response, expanding command jobs into
    // the command followed by its zero-length status packet.
    ucer_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .empty (empty),
        .pop   (pop),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire

// ===== tb/tb_usb_control_endpoint_responder_unit.sv =====
module tb_usb_control_endpoint_responder_unit;

    import ucer_pkg::*;

    // The request channel has no name for the fourth event code, so the bench gives it one.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // Request types used by the directed tests: standard device-to-host,
    // standard host-to-device, and class host-to-device aimed at an interface.
    localparam logic [7:0] RT_STD_IN    = 8'h80;
    localparam logic [7:0] RT_STD_OUT   = 8'h00;
    localparam logic [7:0] RT_CLASS_OUT = 8'h21;

    // Requests that cause no response can still be in flight when the last response
    // has come out, so the bench lets them drain before touching the registers.
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT  = 400_000;
    localparam int unsigned REPORT_LINES = 50;

    logic clk;
    logic rst_n;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    ucer_req_if req_ch ();
    ucer_rsp_if rsp_ch ();

    usb_control_endpoint_responder_unit DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Bench copy of the configuration registers and of the endpoint-zero transfer
    // state. Both are updated at the clock edge where a write or a request is taken.
    cfg_t       reg_shadow;
    logic [7:0] bytes_left;
    logic [7:0] packet_offset;
    logic [2:0] packet_source;
    logic       zlp_owed;
    logic [7:0] active_configuration;

    // Responses the block still owes, oldest first.
    rsp_t expected_responses[$];

    int unsigned sender_idle_pct;
    int unsigned receiver_stall_pct;
    int unsigned items_sent;
    int unsigned responses_seen;
    int unsigned mismatch_count;
    int unsigned cycle_count;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic logic [7:0] max_packet_bytes();
        return 8'd8 << reg_shadow.max_packet_code;
    endfunction

    function automatic void expect_response(input logic [1:0] action,
                                            input logic [2:0] source,
                                            input logic [7:0] offset,
                                            input logic [6:0] count,
                                            input logic [7:0] argument,
                                            input logic       last);
        rsp_t r;
        r.action   = action;
        r.source   = source;
        r.offset   = offset;
        r.count    = count;
        r.argument = argument;
        r.last     = last;
        expected_responses.push_back(r);
    endfunction

    function automatic void clear_transfer_state();
        bytes_left    = 8'd0;
        packet_offset = 8'd0;
        packet_source = SRC_NONE;
        zlp_owed      = 1'b0;
    endfunction

    // Maps wValue of a descriptor read to the descriptor it names. Returns 0 when the
    // descriptor type is not one the endpoint serves. A string index above three
    // is served as an empty descriptor with no source.
    function automatic bit lookup_descriptor(input logic [15:0] value,
                                             output logic [2:0] source,
                                             output logic [7:0] length);
        source = SRC_NONE;
        length = 8'd0;
        case (value[15:8])
            DT_DEVICE:
            begin
                source = SRC_DEVICE;
                length = reg_shadow.device_len;
            end
            DT_CONFIG:
            begin
                source = SRC_CONFIG;
                length = reg_shadow.config_len;
            end
            DT_REPORT:
            begin
                source = SRC_REPORT;
                length = reg_shadow.report_len;
            end
            DT_STRING:
            begin
                case (value[7:0])
                    STR_LANG:
                    begin
                        source = SRC_LANG;
                        length = reg_shadow.lang_len;
                    end
                    STR_VENDOR:
                    begin
                        source = SRC_VENDOR;
                        length = reg_shadow.vendor_str_len;
                    end
                    STR_PRODUCT:
                    begin
                        source = SRC_PRODUCT;
                        length = reg_shadow.product_str_len;
                    end
                    STR_SERIAL:
                    begin
                        source = SRC_SERIAL;
                        length = reg_shadow.serial_str_len;
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
                return 1'b0;
        endcase
        return 1'b1;
    endfunction

    // Emits the next IN packet of the current transfer: a data chunk of at most one
    // max packet, or the owed zero-length packet, or nothing at all.
    function automatic void predict_next_packet();
        logic [7:0] chunk;
        if (bytes_left != 8'd0)
        begin
            chunk = (bytes_left > max_packet_bytes()) ? max_packet_bytes() : bytes_left;
            expect_response(ACT_IN_PACKET, packet_source, packet_offset, chunk[6:0], 8'd0, 1'b1);
            packet_offset = packet_offset + chunk;
            bytes_left    = bytes_left - chunk;
        end
        else if (zlp_owed)
        begin
            expect_response(ACT_IN_PACKET, packet_source, packet_offset, 7'd0, 8'd0, 1'b1);
            zlp_owed = 1'b0;
        end
    endfunction

    function automatic void predict_request(input req_t r);
        logic [1:0] kind;
        logic [2:0] source;
        logic [7:0] length;
        kind = r.request_type[6:5];
        case (r.func)
            FUNC_IN_DONE:
                predict_next_packet();
            FUNC_BUS_RESET:
            begin
                clear_transfer_state();
                active_configuration = 8'd0;
            end
            FUNC_SETUP:
            begin
                // Any setup request abandons the transfer in progress.
                clear_transfer_state();
                if (r.request_type[DIR_IN_BIT])
                begin
                    if (kind == KIND_STANDARD && r.request_code == REQ_READ_DESC &&
                        lookup_descriptor(r.request_value, source, length))
                    begin
                        packet_source = source;
                        packet_offset = 8'd0;
                        if (r.request_length > {8'd0, length})
                        begin
                            // A short reply ends with a zero-length packet when it
                            // fills its last packet exactly.
                            bytes_left = length;
                            zlp_owed   = (length % max_packet_bytes()) == 8'd0;
                        end
                        else
                        begin
                            bytes_left = r.request_length[7:0];
                            zlp_owed   = 1'b0;
                        end
                        predict_next_packet();
                    end
                end
                else if (kind == KIND_STANDARD && r.request_code == REQ_SET_ADDRESS)
                begin
                    expect_response(ACT_SET_ADDRESS, SRC_NONE, 8'd0, 7'd0,
                                    r.request_value[7:0], 1'b0);
                    expect_response(ACT_IN_PACKET, SRC_NONE, 8'd0, 7'd0, 8'd0, 1'b1);
                end
                else if (kind == KIND_STANDARD && r.request_code == REQ_SET_CONFIG)
                begin
                    active_configuration = r.request_value[7:0];
                    expect_response(ACT_SET_CONFIG, SRC_NONE, 8'd0, 7'd0,
                                    active_configuration, 1'b0);
                    expect_response(ACT_IN_PACKET, SRC_NONE, 8'd0, 7'd0, 8'd0, 1'b1);
                end
                else if (kind == KIND_CLASS && r.request_code == REQ_SET_IDLE)
                begin
                    expect_response(ACT_IN_PACKET, SRC_NONE, 8'd0, 7'd0, 8'd0, 1'b1);
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic logic [31:0] register_value(input logic [2:0] index);
        case (index)
            REG_MAX_PACKET:  return {30'd0, reg_shadow.max_packet_code};
            REG_DEVICE_LEN:  return {24'd0, reg_shadow.device_len};
            REG_CONFIG_LEN:  return {24'd0, reg_shadow.config_len};
            REG_REPORT_LEN:  return {24'd0, reg_shadow.report_len};
            REG_LANG_LEN:    return {24'd0, reg_shadow.lang_len};
            REG_VENDOR_LEN:  return {24'd0, reg_shadow.vendor_str_len};
            REG_PRODUCT_LEN: return {24'd0, reg_shadow.product_str_len};
            REG_SERIAL_LEN:  return {24'd0, reg_shadow.serial_str_len};
            default:         return 32'd0;
        endcase
    endfunction

    function automatic req_t make_request(input logic [1:0]  func,
                                          input logic [7:0]  rtype,
                                          input logic [7:0]  code,
                                          input logic [15:0] value,
                                          input logic [15:0] wlen);
        req_t r;
        r.func           = func;
        r.request_type   = rtype;
        r.request_code   = code;
        r.request_value  = value;
        r.request_length = wlen;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Reporting and checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LINES)
        begin
            $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        end
    endtask

    task automatic compare_field(input string field, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("response %0d %s is %0d, expected %0d",
                                      responses_seen, field, got, want));
        end
    endtask

    // Every response taken from the block is matched against the oldest
    // outstanding prediction, one field at a time.
    always @(posedge clk)
    begin : response_checker
        rsp_t want;
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            responses_seen++;
            if (expected_responses.size() == 0)
            begin
                report_mismatch($sformatf("unexpected response %h", rsp_ch.data));
            end
            else
            begin
                want = expected_responses.pop_front();
                compare_field("action",   8'(rsp_ch.data.action),   8'(want.action));
                compare_field("source",   8'(rsp_ch.data.source),   8'(want.source));
                compare_field("offset",   rsp_ch.data.offset,       want.offset);
                compare_field("count",    8'(rsp_ch.data.count),    8'(want.count));
                compare_field("argument", rsp_ch.data.argument,     want.argument);
                compare_field("last",     8'(rsp_ch.data.last),     8'(want.last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Clock, receiver and watchdog
    // ------------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // The response side stalls at random at the current stall rate.
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_usb_control_endpoint_responder_unit failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------

    // One write: a setup cycle, then an access cycle that completes when pready
    // is seen. The bench copy changes at that same edge.
    task automatic write_register(input logic [2:0] index, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        case (index)
            REG_MAX_PACKET:  reg_shadow.max_packet_code = data[1:0];
            REG_DEVICE_LEN:  reg_shadow.device_len      = data[7:0];
            REG_CONFIG_LEN:  reg_shadow.config_len      = data[7:0];
            REG_REPORT_LEN:  reg_shadow.report_len      = data[7:0];
            REG_LANG_LEN:    reg_shadow.lang_len        = data[7:0];
            REG_VENDOR_LEN:  reg_shadow.vendor_str_len  = data[7:0];
            REG_PRODUCT_LEN: reg_shadow.product_str_len = data[7:0];
            REG_SERIAL_LEN:  reg_shadow.serial_str_len  = data[7:0];
            default:
            begin
            end
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_register(input logic [2:0] index);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {index, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        if (prdata !== register_value(index))
        begin
            report_mismatch($sformatf("register %0d reads %h, expected %h",
                                      index, prdata, register_value(index)));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Request channel
    // ------------------------------------------------------------------

    // Offers one request after a random run of idle cycles, each cycle idle at the
    // current idle rate, and predicts its responses at the edge where it is taken.
    // Valid stays high afterwards, so that back-to-back requests go out without a
    // bubble.
    task automatic send_request(input req_t item);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= item;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        predict_request(item);
        if (item.func != FUNC_UNUSED)
        begin
            items_sent++;
        end
    endtask

    // Lets every owed response come out and then allows for requests that are
    // still inside the block without a response to show for it.
    task automatic wait_for_drain();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (expected_responses.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic randomize_registers();
        logic [31:0] data;
        logic [7:0]  length;
        int unsigned mps;
        wait_for_drain();
        data = $urandom;
        write_register(REG_MAX_PACKET, data);
        mps = int'(max_packet_bytes());
        for (int i = REG_DEVICE_LEN; i <= REG_SERIAL_LEN; i++)
        begin
            // Exact multiples of the packet size are favored, because they are
            // the lengths that owe a zero-length packet.
            case ($urandom_range(9))
                0:       length = 8'd0;
                1:       length = 8'hFF;
                2, 3:    length = 8'(mps * $urandom_range(255 / mps));
                default: length = 8'($urandom);
            endcase
            data = $urandom;
            data[7:0] = length;
            write_register(3'(i), data);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Registers must come out of reset with their defaults, and a device
    // descriptor read must use the default 16-byte packet and 18-byte length.
    task automatic test_reset_defaults();
        for (int i = REG_MAX_PACKET; i <= REG_SERIAL_LEN; i++)
        begin
            check_register(3'(i));
        end
        send_request(make_request(FUNC_SETUP, RT_STD_IN, REQ_READ_DESC,
                                  {DT_DEVICE, 8'd0}, 16'hFFFF));
        send_request(make_request(FUNC_IN_DONE, 8'd0, 8'd0, 16'd0, 16'd0));
    endtask

    // Each request the endpoint knows, each string index, and the cases that must
    // stay silent: zero request length, unknown requests, unknown descriptor types,
    // an IN event with nothing left to send, a bus reset, and the unused event code.
    task automatic test_standard_requests();
        send_request(make_request(FUNC_SETUP, RT_STD_OUT, REQ_SET_ADDRESS, 16'hFFFF, 16'd0));
        send_request(make_request(FUNC_SETUP, RT_STD_OUT, REQ_SET_CONFIG, 16'h00A5, 16'd0));
        send_request(make_request(FUNC_SETUP, RT_CLASS_OUT, REQ_SET_IDLE, 16'd0, 16'd0));
        send_request(make_request(FUNC_SETUP, RT_STD_IN, REQ_READ_DESC,
                                  {DT_STRING, STR_LANG}, 16'hFFFF));
        send_request(make_request(FUNC_SETUP, RT_STD_IN, REQ_READ_DESC,
                                  {DT_STRING, STR_VENDOR}, 16'd2));
        // The product string read is left unfinished; the next setup drops it.
        send_request(make_request(FUNC_SETUP, RT_STD_IN, REQ_READ_DESC,
                                  {DT_STRING, STR_PRODUCT}, 16'd26));
        send_request(make_request(FUNC_SETUP, RT_STD_IN, REQ_READ_DESC,
                                  {DT_STRING, STR_SERIAL}, 16'd1));
        // A string index past the table is an empty descriptor: one zero-length packet.
        send_request(make_request(FUNC_SETUP, RT_STD_IN, REQ_READ_DESC,
                                  {DT_STRING, 8'hFF}, 16'd10));
        send_request(make_request(FUNC_SETUP, RT_STD_IN, REQ_READ_DESC,
                                  {DT_REPORT, 8'd0}, 16'd0));
        send_request(make_request(FUNC_SETUP, RT_STD_IN, REQ_READ_DESC,
                                  {DT_CONFIG, 8'd0}, 16'h1000));
        send_request(make_request(FUNC_SETUP, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF));
        send_request(make_request(FUNC_IN_DONE, 8'd0, 8'd0, 16'd0, 16'd0));
        send_request(make_request(FUNC_SETUP, RT_STD_IN, REQ_READ_DESC,
                                  16'h0400, 16'd8));
        send_request(make_request(FUNC_SETUP, RT_STD_IN, REQ_READ_DESC,
                                  {DT_CONFIG, 8'd0}, 16'd40));
        send_request(make_request(FUNC_BUS_RESET, 8'd0, 8'd0, 16'd0, 16'd0));
        send_request(make_request(FUNC_IN_DONE, 8'd0, 8'd0, 16'd0, 16'd0));
        send_request(make_request(FUNC_UNUSED, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF));
    endtask

    // All registers at their lowest and then at their highest values, read back
    // each time. Empty descriptors owe a zero-length packet at once, the largest
    // descriptor spans four maximum-size packets, and a length that fills its last
    // packet exactly ends with a zero-length packet.
    task automatic test_register_extremes();
        wait_for_drain();
        for (int i = REG_MAX_PACKET; i <= REG_SERIAL_LEN; i++)
        begin
            write_register(3'(i), 32'd0);
        end
        for (int i = REG_MAX_PACKET; i <= REG_SERIAL_LEN; i++)
        begin
            check_register(3'(i));
        end
        send_request(make_request(FUNC_SETUP, RT_STD_IN, REQ_READ_DESC,
                                  {DT_DEVICE, 8'd0}, 16'd5));

        wait_for_drain();
        for (int i = REG_MAX_PACKET; i <= REG_SERIAL_LEN; i++)
        begin
            write_register(3'(i), 32'hFFFF_FFFF);
        end
        for (int i = REG_MAX_PACKET; i <= REG_SERIAL_LEN; i++)
        begin
            check_register(3'(i));
        end
        send_request(make_request(FUNC_SETUP, RT_STD_IN, REQ_READ_DESC,
                                  {DT_DEVICE, 8'd0}, 16'hFFFF));
        repeat (4) send_request(make_request(FUNC_IN_DONE, 8'd0, 8'd0, 16'd0, 16'd0));

        wait_for_drain();
        write_register(REG_CONFIG_LEN, 32'd128);
        send_request(make_request(FUNC_SETUP, RT_STD_IN, REQ_READ_DESC,
                                  {DT_CONFIG, 8'd0}, 16'd200));
        repeat (3) send_request(make_request(FUNC_IN_DONE, 8'd0, 8'd0, 16'd0, 16'd0));
    endtask

    // Mostly well-formed control traffic: descriptor reads followed by the IN
    // events that drain them (sometimes cut short, sometimes with one too many),
    // address and configuration commands, HID idle requests and bus resets. The
    // rest is noise with random fields. Registers are re-drawn about every hundred
    // requests, once the block has gone quiet.
    task automatic test_random_traffic(input int unsigned idle_pct,
                                       input int unsigned stall_pct,
                                       input int unsigned goal);
        int unsigned first_item;
        int unsigned next_reconfig;
        logic [7:0]  rtype;
        logic [7:0]  code;
        logic [15:0] value;
        logic [15:0] wlen;
        logic [2:0]  source;
        logic [7:0]  length;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        first_item    = items_sent;
        next_reconfig = items_sent;
        while (items_sent - first_item < goal)
        begin
            if (items_sent >= next_reconfig)
            begin
                randomize_registers();
                next_reconfig = items_sent + 100;
            end
            case ($urandom_range(99)) inside
                [0:49]:
                begin
                    case ($urandom_range(9))
                        0, 1:    value = {DT_DEVICE, 8'($urandom)};
                        2, 3:    value = {DT_CONFIG, 8'($urandom)};
                        4:       value = {DT_REPORT, 8'($urandom)};
                        5, 6, 7: value = {DT_STRING, 8'($urandom_range(3))};
                        8:       value = {DT_STRING, 8'($urandom_range(255, 4))};
                        default: value = 16'($urandom);
                    endcase
                    void'(lookup_descriptor(value, source, length));
                    case ($urandom_range(7))
                        0:       wlen = 16'($urandom_range(8, 1));
                        1:       wlen = {8'd0, length};
                        2:       wlen = {8'd0, length} + 16'd1;
                        3:       wlen = (length == 8'd0) ? 16'd0 : {8'd0, length} - 16'd1;
                        4:       wlen = 16'($urandom);
                        5:       wlen = 16'hFFFF;
                        6:       wlen = 16'($urandom_range(300));
                        default: wlen = 16'd0;
                    endcase
                    rtype = 8'($urandom_range(31));
                    rtype[DIR_IN_BIT] = 1'b1;
                    send_request(make_request(FUNC_SETUP, rtype, REQ_READ_DESC,
                                              value, wlen));
                    while ((bytes_left != 8'd0 || zlp_owed) && $urandom_range(24) != 0)
                    begin
                        send_request(make_request(FUNC_IN_DONE, 8'($urandom), 8'($urandom),
                                                  16'($urandom), 16'($urandom)));
                    end
                    if ($urandom_range(3) == 0)
                    begin
                        send_request(make_request(FUNC_IN_DONE, 8'($urandom), 8'($urandom),
                                                  16'($urandom), 16'($urandom)));
                    end
                end
                [50:64]:
                begin
                    code = $urandom_range(1) ? REQ_SET_ADDRESS : REQ_SET_CONFIG;
                    send_request(make_request(FUNC_SETUP, 8'($urandom_range(31)), code,
                                              16'($urandom), 16'($urandom)));
                end
                [65:71]:
                begin
                    rtype = 8'($urandom_range(31));
                    rtype[6:5] = KIND_CLASS;
                    send_request(make_request(FUNC_SETUP, rtype, REQ_SET_IDLE,
                                              16'($urandom), 16'($urandom)));
                end
                [72:77]:
                    send_request(make_request(FUNC_BUS_RESET, 8'($urandom), 8'($urandom),
                                              16'($urandom), 16'($urandom)));
                [78:84]:
                    send_request(make_request(FUNC_IN_DONE, 8'($urandom), 8'($urandom),
                                              16'($urandom), 16'($urandom)));
                default:
                begin
                    // Noise: known request codes under random request types are
                    // near misses for the decoder; the rest is fully random.
                    case ($urandom_range(5))
                        0:       code = REQ_SET_ADDRESS;
                        1:       code = REQ_READ_DESC;
                        2:       code = REQ_SET_CONFIG;
                        3:       code = REQ_SET_IDLE;
                        default: code = 8'($urandom);
                    endcase
                    send_request(make_request(2'($urandom), 8'($urandom), code,
                                              16'($urandom), 16'($urandom)));
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------

    initial
    begin
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        rst_n        = 1'b0;

        reg_shadow = '{max_packet_code: RST_MAX_PACKET,
                       device_len:      RST_DEVICE_LEN,
                       config_len:      RST_CONFIG_LEN,
                       report_len:      RST_REPORT_LEN,
                       lang_len:        RST_LANG_LEN,
                       vendor_str_len:  RST_VENDOR_LEN,
                       product_str_len: RST_PRODUCT_LEN,
                       serial_str_len:  RST_SERIAL_LEN};
        clear_transfer_state();
        active_configuration = 8'd0;

        items_sent         = 0;
        responses_seen     = 0;
        mismatch_count     = 0;
        sender_idle_pct    = 10;
        receiver_stall_pct = 58;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // The directed tests run with the first idle pattern: a sender that rarely
        // pauses and a receiver that stalls more often than not.
        test_reset_defaults();
        test_standard_requests();
        test_register_extremes();

        // Random traffic, first with the sender busy and the receiver slow, then
        // the other way round, and last at full rate on both sides.
        test_random_traffic(10, 58, 483);
        test_random_traffic(58, 10, 483);
        test_random_traffic(0, 0, 484);

        wait_for_drain();
        if (mismatch_count == 0)
        begin
            $display("tb_usb_control_endpoint_responder_unit passed");
        end
        else
        begin
            $display("tb_usb_control_endpoint_responder_unit failed");
        end
        $finish;
    end

endmodule

// ===== usb_control_endpoint_responder_unit.f =====
design/ucer_pkg.sv
design/ucer_if.sv
design/ucer_regs.sv
design/ucer_front.sv
design/ucer_fifo.sv
design/ucer_back.sv
design/usb_control_endpoint_responder_unit.sv
tb/tb_usb_control_endpoint_responder_unit.sv
